// ===== rtl/ksae_pkg.sv =====
`default_nettype none

package ksae_pkg;

   // Default key word width and direction bit positions
   localparam int KEY_BITS_DEF  = 24;
   localparam int BIT_UP_DEF    = 4;
   localparam int BIT_RIGHT_DEF = 5;
   localparam int BIT_DOWN_DEF  = 6;
   localparam int BIT_LEFT_DEF  = 7;

   // Fixed field widths
   localparam int SENS_W      = 8;
   localparam int REPEAT_W    = 16;
   localparam int HOLD_W      = 32;
   localparam int STICK_W     = 8;
   localparam int CODE_W      = 32;
   localparam int CODE_BYTE_W = 8;
   localparam int CODE_SLOTS  = CODE_W / CODE_BYTE_W;
   localparam int CSR_INDEX_W = 2;

   localparam logic [STICK_W-1:0] STICK_CENTRE = 8'd128;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SENSITIVITY = 2'd0,
      CSR_DELAY       = 2'd1,
      CSR_INTERVAL    = 2'd2,
      CSR_MASK        = 2'd3
   } csr_index_type;

   // Repeat phase written back by the modulo unit
   typedef struct packed {
      logic                valid;
      logic [REPEAT_W-1:0] value;
   } phase_load_type;

endpackage

`default_nettype wire

// ===== rtl/ksae_ifs.sv =====
`default_nettype none

// Sample channel
interface ksae_req_if #(
   parameter int KEY_BITS = ksae_pkg::KEY_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic [KEY_BITS-1:0]          button_bits;
   logic [ksae_pkg::STICK_W-1:0] stick_x;
   logic [ksae_pkg::STICK_W-1:0] stick_y;

   modport source (output valid, output button_bits, output stick_x, output stick_y,
                   input ready);
   modport sink   (input valid, input button_bits, input stick_x, input stick_y,
                   output ready);
endinterface

// Result channel
interface ksae_rsp_if #(
   parameter int KEY_BITS = ksae_pkg::KEY_BITS_DEF
) ();
   logic                                valid;
   logic                                ready;
   logic [KEY_BITS-1:0]                 held_bits;
   logic [KEY_BITS-1:0]                 pressed_bits;
   logic [KEY_BITS-1:0]                 released_bits;
   logic signed [ksae_pkg::STICK_W-1:0] centred_x;
   logic signed [ksae_pkg::STICK_W-1:0] centred_y;
   logic [ksae_pkg::CODE_W-1:0]         key_codes;

   modport source (output valid, output held_bits, output pressed_bits,
                   output released_bits, output centred_x, output centred_y,
                   output key_codes, input ready);
   modport sink   (input valid, input held_bits, input pressed_bits,
                   input released_bits, input centred_x, input centred_y,
                   input key_codes, output ready);
endinterface

`default_nettype wire

// ===== rtl/ksae_phase_div.sv =====
`default_nettype none

// Recomputes the repeat phase, (hold - delay) mod interval, one quotient
// bit per cycle after a write to the delay or interval register.
module ksae_phase_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [ksae_pkg::HOLD_W-1:0]       hold_count,
   input  wire logic [ksae_pkg::REPEAT_W-1:0]     repeat_delay,
   input  wire logic [ksae_pkg::REPEAT_W-1:0]     repeat_interval,
   output logic                                   busy,
   output ksae_pkg::phase_load_type               phase_load
);

   localparam int CNT_W = $clog2(ksae_pkg::HOLD_W);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_LOAD,
      DIV_RUN
   } div_state_type;

   div_state_type                   state_ff, state_in;
   logic [ksae_pkg::HOLD_W-1:0]     dividend_ff, dividend_in;
   logic [ksae_pkg::REPEAT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   ksae_pkg::phase_load_type        load_ff, load_in;
   logic [ksae_pkg::REPEAT_W:0]     trial;

   // Next state and one restoring step
   always_comb begin
      state_in    = state_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      count_in    = count_ff;
      load_in     = '0;
      load_in.value = rem_ff;
      trial       = {rem_ff, dividend_ff[ksae_pkg::HOLD_W-1]};
      if (trial >= {1'b0, repeat_interval}) begin
         trial = trial - {1'b0, repeat_interval};
      end
      case (state_ff)
         DIV_IDLE: begin
         end
         DIV_LOAD: begin
            dividend_in = hold_count - {{(ksae_pkg::HOLD_W-ksae_pkg::REPEAT_W){1'b0}},
                                        repeat_delay};
            rem_in      = '0;
            count_in    = '0;
            state_in    = DIV_RUN;
         end
         DIV_RUN: begin
            rem_in      = trial[ksae_pkg::REPEAT_W-1:0];
            dividend_in = {dividend_ff[ksae_pkg::HOLD_W-2:0], 1'b0};
            count_in    = count_ff + 1'b1;
            if (count_ff == CNT_W'(ksae_pkg::HOLD_W - 1)) begin
               state_in      = DIV_IDLE;
               load_in.valid = 1'b1;
               load_in.value = trial[ksae_pkg::REPEAT_W-1:0];
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
      // a new write restarts the computation
      if (start) begin
         state_in      = DIV_LOAD;
         load_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         load_ff  <= '0;
      end else begin
         state_ff <= state_in;
         load_ff  <= load_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      count_ff    <= count_in;
   end

   assign busy       = (state_ff != DIV_IDLE);
   assign phase_load = load_ff;

endmodule

`default_nettype wire

// ===== rtl/ksae_sample_core.sv =====
`default_nettype none

// Stick emulation, auto-repeat, edge detection and key code packing for the
// sample held in the input register. State advances when the item moves on.
module ksae_sample_core #(
   parameter int KEY_BITS  = ksae_pkg::KEY_BITS_DEF,
   parameter int BIT_UP    = ksae_pkg::BIT_UP_DEF,
   parameter int BIT_RIGHT = ksae_pkg::BIT_RIGHT_DEF,
   parameter int BIT_DOWN  = ksae_pkg::BIT_DOWN_DEF,
   parameter int BIT_LEFT  = ksae_pkg::BIT_LEFT_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 advance,
   input  wire logic [KEY_BITS-1:0]                  button_bits,
   input  wire logic [ksae_pkg::STICK_W-1:0]         stick_x,
   input  wire logic [ksae_pkg::STICK_W-1:0]         stick_y,
   input  wire logic [ksae_pkg::SENS_W-1:0]          dpad_sensitivity,
   input  wire logic [ksae_pkg::REPEAT_W-1:0]        repeat_delay,
   input  wire logic [ksae_pkg::REPEAT_W-1:0]        repeat_interval,
   input  wire logic [KEY_BITS-1:0]                  repeat_mask,
   input  wire ksae_pkg::phase_load_type             phase_load,
   output logic [KEY_BITS-1:0]                       held_bits,
   output logic [KEY_BITS-1:0]                       pressed_bits,
   output logic [KEY_BITS-1:0]                       released_bits,
   output logic signed [ksae_pkg::STICK_W-1:0]       centred_x,
   output logic signed [ksae_pkg::STICK_W-1:0]       centred_y,
   output logic [ksae_pkg::CODE_W-1:0]               key_codes,
   output logic [ksae_pkg::HOLD_W-1:0]               hold_count
);

   localparam int CMP_W  = ksae_pkg::SENS_W + 2;
   localparam int RANK_W = $clog2(KEY_BITS + 1);

   logic [KEY_BITS-1:0]             prev_ff, prev_in;
   logic [ksae_pkg::HOLD_W-1:0]     hold_ff, hold_in;
   logic [ksae_pkg::REPEAT_W-1:0]   phase_ff, phase_in;

   logic signed [CMP_W-1:0]         cx_w, cy_w, sens_w;
   logic                            go_up, go_down, go_right, go_left;
   logic [ksae_pkg::HOLD_W-1:0]     hold_next;
   logic [ksae_pkg::HOLD_W-1:0]     delay_w;
   logic [ksae_pkg::REPEAT_W:0]     phase_inc;
   logic                            at_delay, past_delay, phase_wrap, fire;
   logic [KEY_BITS-1:0]             last;
   logic [RANK_W-1:0]               rank;

   // Centre the sticks
   assign centred_x = ksae_pkg::STICK_W'(stick_x - ksae_pkg::STICK_CENTRE);
   assign centred_y = ksae_pkg::STICK_W'(stick_y - ksae_pkg::STICK_CENTRE);
   assign cx_w      = CMP_W'(centred_x);
   assign cy_w      = CMP_W'(centred_y);
   assign sens_w    = signed'({2'b00, dpad_sensitivity});

   // Stick deflection to direction bits
   always_comb begin
      go_down  = (dpad_sensitivity != '0) && (cy_w >= sens_w);
      go_up    = (dpad_sensitivity != '0) && (cy_w <= -sens_w);
      go_right = (dpad_sensitivity != '0) && (cx_w >= sens_w);
      go_left  = (dpad_sensitivity != '0) && (cx_w <= -sens_w);
      for (int i = 0; i < KEY_BITS; i++) begin
         held_bits[i] = button_bits[i] | ((i == BIT_UP) && go_up) |
                        ((i == BIT_DOWN) && go_down) | ((i == BIT_RIGHT) && go_right) |
                        ((i == BIT_LEFT) && go_left);
      end
   end

   // Auto-repeat: phase tracks (hold - delay) mod interval once past the delay
   assign hold_next  = hold_ff + 1'b1;
   assign delay_w    = {{(ksae_pkg::HOLD_W-ksae_pkg::REPEAT_W){1'b0}}, repeat_delay};
   assign at_delay   = (hold_next == delay_w);
   assign past_delay = (hold_next > delay_w);
   assign phase_inc  = {1'b0, phase_ff} + 1'b1;
   assign phase_wrap = (phase_inc == {1'b0, repeat_interval});

   always_comb begin
      prev_in  = prev_ff;
      hold_in  = hold_ff;
      phase_in = phase_ff;
      fire     = 1'b0;
      if (repeat_interval != '0) begin
         if (prev_ff != held_bits) begin
            hold_in  = '0;
            phase_in = '0;
         end else begin
            hold_in = hold_next;
            fire    = at_delay || (past_delay && phase_wrap);
            if (at_delay || (past_delay && phase_wrap)) begin
               phase_in = '0;
            end else if (past_delay) begin
               phase_in = phase_inc[ksae_pkg::REPEAT_W-1:0];
            end
         end
      end
      if (advance) begin
         prev_in = held_bits;
      end else begin
         hold_in  = hold_ff;
         phase_in = phase_ff;
      end
      if (phase_load.valid) begin
         phase_in = phase_load.value;
      end
   end

   // Edges
   assign last          = fire ? (prev_ff & ~repeat_mask) : prev_ff;
   assign pressed_bits  = ~last & held_bits;
   assign released_bits = last & ~held_bits;

   // Key codes: each pressed key goes to the slot given by its rank
   always_comb begin
      key_codes = '0;
      rank      = '0;
      for (int i = 0; i < KEY_BITS; i++) begin
         rank = RANK_W'($countones(pressed_bits & KEY_BITS'((64'd1 << i) - 64'd1)));
         if (pressed_bits[i] && (rank < RANK_W'(ksae_pkg::CODE_SLOTS))) begin
            key_codes = key_codes |
                        (ksae_pkg::CODE_W'(i + 1) << (rank * ksae_pkg::CODE_BYTE_W));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         hold_ff  <= '0;
         phase_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         hold_ff  <= hold_in;
         phase_ff <= phase_in;
      end
   end

   assign hold_count = hold_ff;

endmodule

`default_nettype wire

// ===== rtl/key_scan_autorepeat_edges.sv =====
`default_nettype none

// Channel    Dir  Handshake       Payload
// req_chan   in   valid / ready   button_bits, stick_x, stick_y
// rsp_chan   out  valid / ready   held/pressed/released bits, centred_x/y, key_codes
// csr        in   csr_we          csr_index, csr_wdata
//
// One sample per cycle while results are taken and no phase rebuild runs;
// an accepted sample passes the input register, then the result register.
// A delay or interval write starts a modulo pass (a load step, then one
// quotient bit per cycle) that rebuilds the repeat phase; no sample is taken
// until it ends. Reset is synchronous and spares only the data registers.
// A stalled result holds its register; the input register takes one more item.
module key_scan_autorepeat_edges #(
   parameter int KEY_BITS  = ksae_pkg::KEY_BITS_DEF,
   parameter int BIT_UP    = ksae_pkg::BIT_UP_DEF,
   parameter int BIT_RIGHT = ksae_pkg::BIT_RIGHT_DEF,
   parameter int BIT_DOWN  = ksae_pkg::BIT_DOWN_DEF,
   parameter int BIT_LEFT  = ksae_pkg::BIT_LEFT_DEF,
   parameter int CSR_W     = (KEY_BITS > ksae_pkg::REPEAT_W) ? KEY_BITS : ksae_pkg::REPEAT_W
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ksae_req_if.sink                               req_chan,
   ksae_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [ksae_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]                  csr_wdata
);

   // Configuration registers
   logic [ksae_pkg::SENS_W-1:0]   sens_ff;
   logic [ksae_pkg::REPEAT_W-1:0] delay_ff;
   logic [ksae_pkg::REPEAT_W-1:0] interval_ff;
   logic [KEY_BITS-1:0]           mask_ff;
   logic                          div_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff     <= '0;
         delay_ff    <= '0;
         interval_ff <= '0;
         mask_ff     <= '0;
      end else if (csr_we) begin
         case (ksae_pkg::csr_index_type'(csr_index))
            ksae_pkg::CSR_SENSITIVITY: sens_ff     <= csr_wdata[ksae_pkg::SENS_W-1:0];
            ksae_pkg::CSR_DELAY:       delay_ff    <= csr_wdata[ksae_pkg::REPEAT_W-1:0];
            ksae_pkg::CSR_INTERVAL:    interval_ff <= csr_wdata[ksae_pkg::REPEAT_W-1:0];
            ksae_pkg::CSR_MASK:        mask_ff     <= csr_wdata[KEY_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign div_start = csr_we &&
                      ((csr_index == ksae_pkg::CSR_DELAY) ||
                       (csr_index == ksae_pkg::CSR_INTERVAL));

   // Handshake and stage valids
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, advance, accept, busy;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !busy && (!s1_valid_ff || out_free);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   logic [KEY_BITS-1:0]          s1_buttons_ff;
   logic [ksae_pkg::STICK_W-1:0] s1_x_ff, s1_y_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_buttons_ff <= req_chan.button_bits;
         s1_x_ff       <= req_chan.stick_x;
         s1_y_ff       <= req_chan.stick_y;
      end
   end

   // Sample logic and phase rebuild
   logic [KEY_BITS-1:0]                 held_w, pressed_w, released_w;
   logic signed [ksae_pkg::STICK_W-1:0] cx_w, cy_w;
   logic [ksae_pkg::CODE_W-1:0]         codes_w;
   logic [ksae_pkg::HOLD_W-1:0]         hold_w;
   ksae_pkg::phase_load_type            phase_load;

   ksae_sample_core #(
      .KEY_BITS  (KEY_BITS),
      .BIT_UP    (BIT_UP),
      .BIT_RIGHT (BIT_RIGHT),
      .BIT_DOWN  (BIT_DOWN),
      .BIT_LEFT  (BIT_LEFT)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .button_bits      (s1_buttons_ff),
      .stick_x          (s1_x_ff),
      .stick_y          (s1_y_ff),
      .dpad_sensitivity (sens_ff),
      .repeat_delay     (delay_ff),
      .repeat_interval  (interval_ff),
      .repeat_mask      (mask_ff),
      .phase_load       (phase_load),
      .held_bits        (held_w),
      .pressed_bits     (pressed_w),
      .released_bits    (released_w),
      .centred_x        (cx_w),
      .centred_y        (cy_w),
      .key_codes        (codes_w),
      .hold_count       (hold_w)
   );

   ksae_phase_div u_div (
      .clock           (clock),
      .reset           (reset),
      .start           (div_start),
      .hold_count      (hold_w),
      .repeat_delay    (delay_ff),
      .repeat_interval (interval_ff),
      .busy            (busy),
      .phase_load      (phase_load)
   );

   // Result register
   logic [KEY_BITS-1:0]                 held_ff, pressed_ff, released_ff;
   logic signed [ksae_pkg::STICK_W-1:0] cx_ff, cy_ff;
   logic [ksae_pkg::CODE_W-1:0]         codes_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         held_ff     <= held_w;
         pressed_ff  <= pressed_w;
         released_ff <= released_w;
         cx_ff       <= cx_w;
         cy_ff       <= cy_w;
         codes_ff    <= codes_w;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.held_bits     = held_ff;
   assign rsp_chan.pressed_bits  = pressed_ff;
   assign rsp_chan.released_bits = released_ff;
   assign rsp_chan.centred_x     = cx_ff;
   assign rsp_chan.centred_y     = cy_ff;
   assign rsp_chan.key_codes     = codes_ff;

`ifndef SYNTH
   // pressed keys are held, released keys are not
   a_edges_vs_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (((pressed_ff & ~held_ff) == '0) && ((released_ff & held_ff) == '0)))
      else $error("edge bits disagree with held word");

   // first code slot filled exactly when something was pressed
   a_codes_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((codes_ff[ksae_pkg::CODE_BYTE_W-1:0] != '0) == (pressed_ff != '0)))
      else $error("key code slot zero inconsistent with pressed bits");

   // no sample accepted while the phase is rebuilt
   a_busy_empty: assert property (@(posedge clock) disable iff (reset)
      busy |-> !accept)
      else $error("sample accepted during phase rebuild");

   // delay or interval write starts the rebuild
   a_write_starts: assert property (@(posedge clock) disable iff (reset)
      div_start |=> busy)
      else $error("phase rebuild did not start");
`endif

endmodule

`default_nettype wire

// ===== tb/keypad_event_checker.sv =====
`timescale 1ns / 100ps

// Watches the sample, result and register ports of the key scanner, predicts
// each result from the accepted samples and compares it field by field.
module keypad_event_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ksae_req_if                                    req_mon,
   ksae_rsp_if                                    rsp_mon,
   input  wire logic                              csr_we,
   input  wire logic [ksae_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [23:0]                       csr_wdata,
   output int unsigned                            pending,
   output int unsigned                            results_seen,
   output int unsigned                            failures
);
   import ksae_pkg::*;

   localparam int KB = KEY_BITS_DEF;

   typedef struct packed {
      logic [KB-1:0]          held;
      logic [KB-1:0]          pressed;
      logic [KB-1:0]          released;
      logic [STICK_W-1:0]     cx;
      logic [STICK_W-1:0]     cy;
      logic [CODE_W-1:0]      codes;
   } key_report_t;

   key_report_t expected_reports[$];

   // register copies
   logic [SENS_W-1:0]   sens_reg;
   logic [REPEAT_W-1:0] delay_reg;
   logic [REPEAT_W-1:0] interval_reg;
   logic [KB-1:0]       mask_reg;

   // scanner state
   logic [KB-1:0]       last_held;
   logic [HOLD_W-1:0]   hold_count;

   // one sample in, one report out; advances the hold state
   function automatic key_report_t scan_sample(input logic [KB-1:0] raw,
                                               input logic [STICK_W-1:0] sx,
                                               input logic [STICK_W-1:0] sy);
      key_report_t r;
      logic [KB-1:0] word;
      logic [KB-1:0] prior;
      int cx;
      int cy;
      int sens;
      int slot;
      r = '0;
      word = raw;
      cx = int'(sx) - int'(STICK_CENTRE);
      cy = int'(sy) - int'(STICK_CENTRE);
      sens = int'(sens_reg);

      // stick deflection emulates the direction pad
      if (sens > 0) begin
         if (cy >= sens) word[BIT_DOWN_DEF] = 1'b1;
         if (cy <= -sens) word[BIT_UP_DEF] = 1'b1;
         if (cx >= sens) word[BIT_RIGHT_DEF] = 1'b1;
         if (cx <= -sens) word[BIT_LEFT_DEF] = 1'b1;
      end

      // auto-repeat: the masked keys of a held word periodically look newly pressed
      prior = last_held;
      if (interval_reg != '0) begin
         if (prior != word) begin
            hold_count = '0;
         end else begin
            hold_count = hold_count + 1;
            if (hold_count >= HOLD_W'(delay_reg) &&
                ((hold_count - HOLD_W'(delay_reg)) % HOLD_W'(interval_reg)) == '0)
               prior = prior & ~mask_reg;
         end
      end

      r.held     = word;
      r.pressed  = ~prior & word;
      r.released = prior & ~word;
      r.cx       = sx - STICK_CENTRE;
      r.cy       = sy - STICK_CENTRE;
      last_held  = word;

      // first four pressed keys, 1-based, lowest byte first
      slot = 0;
      for (int i = 0; i < KB; i++) begin
         if (r.pressed[i] && slot < CODE_SLOTS) begin
            r.codes[slot*CODE_BYTE_W +: CODE_BYTE_W] = CODE_BYTE_W'(i + 1);
            slot++;
         end
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      key_report_t want;
      if (reset) begin
         sens_reg     = '0;
         delay_reg    = '0;
         interval_reg = '0;
         mask_reg     = '0;
         last_held    = '0;
         hold_count   = '0;
         expected_reports.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SENSITIVITY: sens_reg = csr_wdata[SENS_W-1:0];
               CSR_DELAY:       delay_reg = csr_wdata[REPEAT_W-1:0];
               CSR_INTERVAL:    interval_reg = csr_wdata[REPEAT_W-1:0];
               CSR_MASK:        mask_reg = csr_wdata[KB-1:0];
               default: ;
            endcase
         end

         // accepted sample
         if (req_mon.valid && req_mon.ready)
            expected_reports.push_back(scan_sample(req_mon.button_bits,
                                                   req_mon.stick_x, req_mon.stick_y));

         // accepted result
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reports.size() == 0) begin
               $error("result item with no sample outstanding");
               failures++;
            end else begin
               want = expected_reports.pop_front();
               check_field("held_bits", 32'(want.held), 32'(rsp_mon.held_bits));
               check_field("pressed_bits", 32'(want.pressed), 32'(rsp_mon.pressed_bits));
               check_field("released_bits", 32'(want.released),
                           32'(rsp_mon.released_bits));
               check_field("centred_x", {24'd0, want.cx}, {24'd0, rsp_mon.centred_x});
               check_field("centred_y", {24'd0, want.cy}, {24'd0, rsp_mon.centred_y});
               check_field("key_codes", want.codes, rsp_mon.key_codes);
               results_seen++;
            end
         end
      end
      pending = expected_reports.size();
   end

endmodule

// ===== tb/tb_key_scan_autorepeat_edges.sv =====
`timescale 1ns / 100ps

module tb_key_scan_autorepeat_edges;
   import ksae_pkg::*;

   localparam int NUM_PHASES      = 9;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int NUM_DIRECTED    = 20;
   localparam int IDLE_LIMIT      = 5000;
   localparam int SETTLE_CYCLES   = 20;

   typedef struct packed {
      logic [23:0] buttons;
      logic [7:0]  x;
      logic [7:0]  y;
   } sample_t;

   typedef struct {
      logic [7:0]  sens;
      logic [15:0] delay;
      logic [15:0] interval;
      logic [23:0] mask;
      int          max_run;
   } setting_t;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   logic [23:0]   csr_wdata;
   logic          steady = 1'b0;
   int unsigned   pending;
   int unsigned   results_seen;
   int unsigned   failures;
   int unsigned   samples_sent = 0;
   int unsigned   idle_cycles = 0;

   // register settings per phase: sensitivity, delay, interval, mask, longest hold run
   setting_t phases [NUM_PHASES] = '{
      '{8'd64,  16'd2,     16'd3,     24'hFFFFFF, 12},
      '{8'd0,   16'd0,     16'd1,     24'hFFFFFF, 8},
      '{8'd128, 16'd65535, 16'd65535, 24'h000000, 16},
      '{8'd1,   16'd5,     16'd2,     24'h5A3C96, 16},
      '{8'd127, 16'd0,     16'd0,     24'hFFFFFF, 10},
      '{8'd200, 16'd40,    16'd10,    24'h0F0F0F, 120},
      '{8'd40,  16'd1,     16'd65535, 24'h0000F0, 12},
      '{8'd96,  16'd3,     16'd4,     24'hA5C3E1, 20},
      '{8'd0,   16'd0,     16'd0,     24'h000000, 10}
   };

   // directed samples, run under the first setting (threshold 64)
   sample_t directed [NUM_DIRECTED] = '{
      '{24'h000000, 8'd128, 8'd128},
      '{24'hFFFFFF, 8'd0,   8'd255},
      '{24'hFFFFFF, 8'd0,   8'd255},
      '{24'hFFFFFF, 8'd0,   8'd255},
      '{24'hFFFFFF, 8'd0,   8'd255},
      '{24'hFFFFFF, 8'd0,   8'd255},
      '{24'hFFFFFF, 8'd0,   8'd255},
      '{24'h000001, 8'd192, 8'd64},
      '{24'h800000, 8'd191, 8'd65},
      '{24'h555555, 8'd64,  8'd192},
      '{24'hAAAAAA, 8'd65,  8'd191},
      '{24'h00000F, 8'd127, 8'd129},
      '{24'h000000, 8'd255, 8'd0},
      '{24'h000000, 8'd255, 8'd0},
      '{24'hF0F0F0, 8'd129, 8'd127},
      '{24'h000001, 8'd128, 8'd128},
      '{24'h800000, 8'd128, 8'd128},
      '{24'hC00003, 8'd128, 8'd128},
      '{24'hFFFFFF, 8'd128, 8'd128},
      '{24'h000000, 8'd128, 8'd128}
   };

   ksae_req_if req_chan ();
   ksae_rsp_if rsp_chan ();

   key_scan_autorepeat_edges dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   keypad_event_checker event_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .pending      (pending),
      .results_seen (results_seen),
      .failures     (failures)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side stalls about 30% of cycles unless in a steady stretch
   always @(negedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(99) >= 30);
   end

   // watchdog on cycles with no item accepted on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // offer one sample, with random gaps before it; returns at a falling edge
   task automatic send_sample(input sample_t s);
      while (!steady && $urandom_range(99) < 30) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.button_bits <= s.buttons;
      req_chan.stick_x     <= s.x;
      req_chan.stick_y     <= s.y;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      samples_sent++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   initial begin
      sample_t  s;
      setting_t cfg;
      int       run;
      int       n;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_SENSITIVITY;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.button_bits = '0;
      req_chan.stick_x     = '0;
      req_chan.stick_y     = '0;
      rsp_chan.ready       = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         cfg = phases[ph];
         drain();

         // program all four registers while the scanner is idle
         csr_we    <= 1'b1;
         csr_index <= CSR_SENSITIVITY;
         csr_wdata <= 24'(cfg.sens);
         @(negedge clock);
         csr_index <= CSR_DELAY;
         csr_wdata <= 24'(cfg.delay);
         @(negedge clock);
         csr_index <= CSR_INTERVAL;
         csr_wdata <= 24'(cfg.interval);
         @(negedge clock);
         csr_index <= CSR_MASK;
         csr_wdata <= cfg.mask;
         @(negedge clock);
         csr_we <= 1'b0;

         steady = (ph == 3);
         if (ph == 0) begin
            foreach (directed[i]) send_sample(directed[i]);
         end

         // mostly held runs of one sample, the rest single noise items
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            case ($urandom_range(3))
               0: s.buttons = 24'($urandom());
               1: s.buttons = 24'd1 << $urandom_range(23);
               2: s.buttons = 24'($urandom() & $urandom());
               default: s.buttons = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
            endcase
            case ($urandom_range(3))
               0: s.x = STICK_CENTRE;
               1: s.x = STICK_CENTRE + cfg.sens;
               2: s.x = STICK_CENTRE - cfg.sens;
               default: s.x = 8'($urandom_range(255));
            endcase
            case ($urandom_range(3))
               0: s.y = STICK_CENTRE;
               1: s.y = STICK_CENTRE + cfg.sens;
               2: s.y = STICK_CENTRE - cfg.sens;
               default: s.y = 8'($urandom_range(255));
            endcase
            run = ($urandom_range(99) < 80) ? $urandom_range(cfg.max_run, 1) : 1;
            repeat (run) begin
               send_sample(s);
               n++;
            end
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d samples under %0d register settings, %0d results checked.",
               samples_sent, NUM_PHASES, results_seen);
      $display("Covered stick thresholds, repeat timing at its limits and key code packing.");
      if (failures == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ksae_pkg.sv
rtl/ksae_ifs.sv
rtl/ksae_phase_div.sv
rtl/ksae_sample_core.sv
rtl/key_scan_autorepeat_edges.sv
tb/keypad_event_checker.sv
tb/tb_key_scan_autorepeat_edges.sv
